// ----- rtl/imubgc_pkg.sv -----
// shared constants, types and helpers for the imu gravity compensation core
`timescale 1ns / 1ps
package imubgc_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam logic [15:0] CAL_SAMPLES_RESET = 16'd100;

  localparam logic signed [16:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;

  // pi / 23040 in units of 2^-32
  localparam logic [19:0] RAD_PER_UNIT_Q32 = 20'd585635;

  localparam int T_W = 36;
  localparam logic signed [T_W-1:0] Q30_ONE = T_W'(64'sd1073741824);

  typedef struct packed {
    logic signed [15:0] ang;
    logic               flip;
  } fold_t;

  // wrap to half a turn, then reflect into a quarter turn
  function automatic fold_t fold_angle(input logic signed [15:0] a);
    logic signed [16:0] w;
    fold_t f;
    w = 17'(a);
    if (w > HALF_TURN) w = w - FULL_TURN;
    if (w < -HALF_TURN) w = w + FULL_TURN;
    f.flip = 1'b0;
    if (w > QUARTER_TURN) begin
      w = HALF_TURN - w;
      f.flip = 1'b1;
    end else if (w < -QUARTER_TURN) begin
      w = -HALF_TURN - w;
      f.flip = 1'b1;
    end
    f.ang = w[15:0];
    return f;
  endfunction

  // horner divisors of the sine and cosine series
  function automatic logic [7:0] series_div(input logic is_cos, input logic [2:0] idx);
    logic [7:0] d;
    d = 8'd1;
    if (is_cos) begin
      case (idx)
        3'd0: d = 8'd182;
        3'd1: d = 8'd132;
        3'd2: d = 8'd90;
        3'd3: d = 8'd56;
        3'd4: d = 8'd30;
        3'd5: d = 8'd12;
        3'd6: d = 8'd2;
        default: d = 8'd1;
      endcase
    end else begin
      case (idx)
        3'd0: d = 8'd156;
        3'd1: d = 8'd110;
        3'd2: d = 8'd72;
        3'd3: d = 8'd42;
        3'd4: d = 8'd20;
        3'd5: d = 8'd6;
        default: d = 8'd1;
      endcase
    end
    return d;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) r = 24'sh7FFFFF;
    else if (v < -28'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
    logic signed [19:0] r;
    if (v > 22'sd524287) r = 20'sh7FFFF;
    else if (v < -22'sd524288) r = 20'sh80000;
    else r = v[19:0];
    return r;
  endfunction

endpackage

// ----- rtl/imubgc_if.sv -----
// channel interfaces: imu samples in, compensated results out, calibration register write
`timescale 1ns / 1ps
interface imubgc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] accel_x;
  logic signed [23:0] accel_y;
  logic signed [23:0] accel_z;
  logic signed [19:0] raw_yaw_rate;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic        [31:0] sample_tag;
  modport source (output valid, accel_x, accel_y, accel_z, raw_yaw_rate, roll_angle,
                  pitch_angle, sample_tag, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, raw_yaw_rate, roll_angle,
                pitch_angle, sample_tag, output ready);
endinterface

interface imubgc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] forward_accel;
  logic signed [19:0] yaw_rate;
  logic        [31:0] out_tag;
  modport source (output valid, forward_accel, yaw_rate, out_tag, input ready);
  modport sink (input valid, forward_accel, yaw_rate, out_tag, output ready);
endinterface

interface imubgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] calibration_samples;
  modport source (output valid, calibration_samples, input ready);
  modport sink (input valid, calibration_samples, output ready);
endinterface

// ----- rtl/imu_bias_calibration_gravity_comp_core.sv -----
// imu gravity compensation with static bias calibration: sequencer and serial arithmetic units
// Usage:
// sample_in carries one imu sample per transaction (three accelerations, yaw rate, roll,
// pitch, tag). cfg writes the calibration sample count; write it only while the core is idle.
// The first calibration_samples samples (0 counts as 1) are averaged into gravity magnitude,
// y-axis bias and yaw rate bias and give no result. Each later sample gives one transaction
// on result_out: forward acceleration and yaw rate, both corrected and saturated, with the tag.
// One sample at a time is in flight. All arithmetic runs through a shared bit-serial
// multiplier, a bit-serial restoring divider and a two-bit-a-step square root, so the
// sample time is set by those units: roughly 20 products and 13 divisions per sample;
// the closing calibration sample adds three divisions and one product.
// A finished result sits in the output register; a new sample is taken while it waits, and
// the next result waits in the sequencer until the register frees, stalling sample_in.
// Synchronous reset clears the calibration state and restores the sample count to 100.
`timescale 1ns / 1ps
module imu_bias_calibration_gravity_comp_core
  import imubgc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  imubgc_in_if.sink    sample_in,
  imubgc_out_if.source result_out,
  imubgc_cfg_if.sink   cfg
);

  localparam int MUL_W = (COUNT_BITS + 20 > 36) ? COUNT_BITS + 20 : 36;
  localparam int PW    = 2 * MUL_W + 1;
  localparam int NUM_W = COUNT_BITS + 44;
  localparam int DEN_W = COUNT_BITS + 16;
  localparam int NS_W  = COUNT_BITS + 25;
  localparam int AS_W  = COUNT_BITS + 24;
  localparam int US_W  = COUNT_BITS + 18;
  localparam int RS_W  = COUNT_BITS + 20;
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS + 1 : 17;
  localparam int SQ_W  = 50;
  localparam int MC_W  = $clog2(MUL_W + 1);
  localparam int DC_W  = $clog2(NUM_W + 2);
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
  localparam logic signed [NUM_W+1:0] BIAS_MAX = (NUM_W+2)'(64'sd16777215);
  localparam logic signed [NUM_W+1:0] BIAS_MIN = -(NUM_W+2)'(64'sd16777216);

  typedef enum logic [4:0] {
    S_IDLE, S_X, S_XW, S_X2, S_X2W, S_TM, S_TMW, S_TD, S_FIN, S_SW, S_U, S_UW,
    S_GY, S_GYW, S_SQ, S_SQW, S_RT, S_RTW, S_G, S_GW, S_R, S_RW, S_B, S_BW, S_BD, S_EMIT
  } state_t;

  // signed shift right by k with rounding to nearest, ties away from zero
  function automatic logic signed [PW-1:0] rshr(input logic signed [PW-1:0] v, input int k);
    logic [PW-1:0] m;
    logic [PW-1:0] half;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    half = (PW'(1) << k) >> 1;
    m = (m + half) >> k;
    return v[PW-1] ? -$signed(m) : $signed(m);
  endfunction

  state_t state;

  logic [15:0] cal_samples;
  logic        calibrated;
  logic [COUNT_BITS-1:0] sample_count;
  logic [COUNT_BITS-1:0] n_cal;
  logic [NS_W-1:0]          norm_sum;
  logic signed [AS_W-1:0]   axis_sum_y;
  logic signed [US_W-1:0]   unit_sum_y;
  logic signed [RS_W-1:0]   rate_sum;
  logic signed [24:0]       gravity_mag;
  logic signed [24:0]       axis_bias_y;
  logic signed [20:0]       rate_bias;

  // latched sample
  logic signed [23:0] ax [3];
  logic signed [19:0] rate;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic [31:0]        tag;

  logic               trig_cos;
  logic [2:0]         idx;
  logic signed [33:0] x;
  logic signed [33:0] x2;
  logic signed [T_W-1:0] t;
  logic signed [17:0] sr;
  logic signed [17:0] cp;
  logic signed [17:0] u1;
  logic signed [25:0] gy;
  logic [SQ_W-1:0]    sq;

  fold_t fold_cur;
  assign fold_cur = fold_angle(trig_cos ? pitch : roll);

  // serial multiplier
  logic                     mul_go;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                     m_busy;
  logic [2*MUL_W-1:0]       m_acc, m_a;
  logic [MUL_W-1:0]         m_b;
  logic                     m_neg;
  logic [MC_W-1:0]          m_cnt;
  logic signed [PW-1:0]     mul_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_busy <= 1'b0;
    end else if (mul_go) begin
      m_busy <= 1'b1;
      m_acc  <= '0;
      m_a    <= (2*MUL_W)'(mul_a[MUL_W-1] ? MUL_W'(-mul_a) : MUL_W'(mul_a));
      m_b    <= mul_b[MUL_W-1] ? MUL_W'(-mul_b) : MUL_W'(mul_b);
      m_neg  <= mul_a[MUL_W-1] ^ mul_b[MUL_W-1];
      m_cnt  <= MC_W'(MUL_W);
    end else if (m_busy) begin
      if (m_b[0]) m_acc <= m_acc + m_a;
      m_a   <= m_a << 1;
      m_b   <= m_b >> 1;
      m_cnt <= m_cnt - 1'b1;
      if (m_cnt == MC_W'(1)) m_busy <= 1'b0;
    end
  end

  assign mul_p = m_neg ? -$signed({1'b0, m_acc}) : $signed({1'b0, m_acc});

  // serial restoring divider, quotient rounded to nearest
  logic                     div_go;
  logic signed [NUM_W-1:0]  d_num;
  logic [DEN_W-1:0]         d_den;
  logic                     d_busy;
  logic [NUM_W:0]           d_q;
  logic [DEN_W-1:0]         d_rem, d_dv;
  logic                     d_neg;
  logic [DC_W-1:0]          d_cnt;
  logic [DEN_W:0]           d_sh;
  logic [DEN_W+1:0]         d_diff;
  logic signed [NUM_W+1:0]  d_res;

  assign d_sh   = {d_rem, d_q[NUM_W]};
  assign d_diff = {1'b0, d_sh} - {2'b00, d_dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_busy <= 1'b0;
    end else if (div_go) begin
      d_busy <= 1'b1;
      d_q    <= (NUM_W+1)'(d_num[NUM_W-1] ? NUM_W'(-d_num) : NUM_W'(d_num))
                + (NUM_W+1)'(d_den >> 1);
      d_rem  <= '0;
      d_dv   <= d_den;
      d_neg  <= d_num[NUM_W-1];
      d_cnt  <= DC_W'(NUM_W + 1);
    end else if (d_busy) begin
      d_rem <= d_diff[DEN_W+1] ? d_sh[DEN_W-1:0] : d_diff[DEN_W-1:0];
      d_q   <= {d_q[NUM_W-1:0], ~d_diff[DEN_W+1]};
      d_cnt <= d_cnt - 1'b1;
      if (d_cnt == DC_W'(1)) d_busy <= 1'b0;
    end
  end

  assign d_res = d_neg ? -$signed({1'b0, d_q}) : $signed({1'b0, d_q});

  // square root, two bits of the radicand per step
  logic            sqrt_go;
  logic            s_busy;
  logic [SQ_W-1:0] s_rem, s_r, s_bit;
  logic [24:0]     norm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_busy <= 1'b0;
    end else if (sqrt_go) begin
      s_busy <= 1'b1;
      s_rem  <= sq;
      s_r    <= '0;
      s_bit  <= SQ_W'(1) << 48;
    end else if (s_busy) begin
      if (s_rem >= s_r + s_bit) begin
        s_rem <= s_rem - (s_r + s_bit);
        s_r   <= (s_r >> 1) + s_bit;
      end else begin
        s_r <= s_r >> 1;
      end
      s_bit <= s_bit >> 2;
      if (s_bit == SQ_W'(1)) s_busy <= 1'b0;
    end
  end

  assign norm = (s_rem > s_r) ? 25'(s_r + 1'b1) : 25'(s_r);

  // operand selection for the serial units
  always_comb begin
    mul_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_go  = 1'b0;
    d_num   = '0;
    d_den   = '0;
    sqrt_go = 1'b0;
    case (state)
      S_X: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(fold_cur.ang);
        mul_b  = MUL_W'($signed({1'b0, RAD_PER_UNIT_Q32}));
      end
      S_X2: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(x);
        mul_b  = MUL_W'(x);
      end
      S_TM: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(x2);
        mul_b  = MUL_W'(t);
      end
      S_TMW: begin
        div_go = !m_busy;
        d_num  = NUM_W'(rshr(mul_p, 30));
        d_den  = DEN_W'(series_div(trig_cos, idx));
      end
      S_FIN: begin
        mul_go = !trig_cos;
        mul_a  = MUL_W'(x);
        mul_b  = MUL_W'(t);
      end
      S_U: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(sr);
        mul_b  = MUL_W'(cp);
      end
      S_GY: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(gravity_mag);
        mul_b  = MUL_W'(u1);
      end
      S_SQ: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(ax[idx[1:0]]);
        mul_b  = MUL_W'(ax[idx[1:0]]);
      end
      S_RT: sqrt_go = 1'b1;
      S_G: begin
        div_go = 1'b1;
        d_num  = NUM_W'($signed({1'b0, norm_sum}));
        d_den  = DEN_W'(n_cal);
      end
      S_R: begin
        div_go = 1'b1;
        d_num  = NUM_W'(rate_sum);
        d_den  = DEN_W'(n_cal);
      end
      S_B: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(gravity_mag);
        mul_b  = MUL_W'(unit_sum_y);
      end
      S_BW: begin
        div_go = !m_busy;
        d_num  = (NUM_W'(axis_sum_y) <<< 16) - NUM_W'(mul_p);
        d_den  = {n_cal, 16'd0};
      end
      default: ;
    endcase
  end

  logic [CMP_W-1:0]      cnt_next;
  logic [CMP_W-1:0]      target;
  logic signed [27:0]    fwd_sum;
  logic signed [21:0]    yaw_sum;
  logic                  out_free;

  assign target   = (cal_samples == 16'd0) ? CMP_W'(1) : CMP_W'(cal_samples);
  assign cnt_next = (sample_count < COUNT_LIMIT) ? CMP_W'(sample_count) + 1'b1
                                                 : CMP_W'(sample_count);
  assign fwd_sum  = -(28'(ax[1]) - 28'(gy) - 28'(axis_bias_y));
  assign yaw_sum  = 22'(rate) - 22'(rate_bias);
  assign out_free = !result_out.valid || result_out.ready;

  assign sample_in.ready = (state == S_IDLE);
  assign cfg.ready       = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RESET;
    end else if (cfg.valid) begin
      cal_samples <= cfg.calibration_samples;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      calibrated       <= 1'b0;
      sample_count     <= '0;
      norm_sum         <= '0;
      axis_sum_y       <= '0;
      unit_sum_y       <= '0;
      rate_sum         <= '0;
      gravity_mag      <= '0;
      axis_bias_y      <= '0;
      rate_bias        <= '0;
      result_out.valid <= 1'b0;
    end else begin
      // a result issued this cycle refills the register itself
      if (result_out.valid && result_out.ready && state != S_EMIT) result_out.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample_in.valid) begin
            ax[0]    <= sample_in.accel_x;
            ax[1]    <= sample_in.accel_y;
            ax[2]    <= sample_in.accel_z;
            rate     <= sample_in.raw_yaw_rate;
            roll     <= sample_in.roll_angle;
            pitch    <= sample_in.pitch_angle;
            tag      <= sample_in.sample_tag;
            trig_cos <= 1'b0;
            state    <= S_X;
          end
        end
        S_X: state <= S_XW;
        S_XW: begin
          if (!m_busy) begin
            x     <= 34'(rshr(mul_p, 2));
            state <= S_X2;
          end
        end
        S_X2: state <= S_X2W;
        S_X2W: begin
          if (!m_busy) begin
            x2    <= 34'(rshr(mul_p, 30));
            t     <= Q30_ONE;
            idx   <= '0;
            state <= S_TM;
          end
        end
        S_TM: state <= S_TMW;
        S_TMW: if (!m_busy) state <= S_TD;
        S_TD: begin
          if (!d_busy) begin
            t   <= Q30_ONE - T_W'(d_res);
            idx <= idx + 1'b1;
            // sine runs six horner steps, cosine seven
            state <= (idx == (trig_cos ? 3'd6 : 3'd5)) ? S_FIN : S_TM;
          end
        end
        S_FIN: begin
          if (trig_cos) begin
            cp    <= fold_cur.flip ? 18'(-rshr(PW'(t), 14)) : 18'(rshr(PW'(t), 14));
            state <= S_U;
          end else begin
            state <= S_SW;
          end
        end
        S_SW: begin
          if (!m_busy) begin
            sr       <= 18'(rshr(rshr(mul_p, 30), 14));
            trig_cos <= 1'b1;
            state    <= S_X;
          end
        end
        S_U: state <= S_UW;
        S_UW: begin
          if (!m_busy) begin
            u1    <= 18'(rshr(mul_p, 16));
            idx   <= '0;
            sq    <= '0;
            state <= calibrated ? S_GY : S_SQ;
          end
        end
        S_GY: state <= S_GYW;
        S_GYW: begin
          if (!m_busy) begin
            gy    <= 26'(rshr(mul_p, 16));
            state <= S_EMIT;
          end
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          if (!m_busy) begin
            sq    <= sq + SQ_W'(mul_p);
            idx   <= idx + 1'b1;
            state <= (idx == 3'd2) ? S_RT : S_SQ;
          end
        end
        S_RT: state <= S_RTW;
        S_RTW: begin
          if (!s_busy) begin
            norm_sum     <= norm_sum + NS_W'(norm);
            axis_sum_y   <= axis_sum_y + AS_W'(ax[1]);
            unit_sum_y   <= unit_sum_y + US_W'(u1);
            rate_sum     <= rate_sum + RS_W'(rate);
            sample_count <= COUNT_BITS'(cnt_next);
            n_cal        <= COUNT_BITS'(cnt_next);
            if (cnt_next < target && cnt_next < CMP_W'(COUNT_LIMIT)) state <= S_IDLE;
            else state <= S_G;
          end
        end
        S_G: state <= S_GW;
        S_GW: begin
          if (!d_busy) begin
            gravity_mag <= 25'(d_res);
            state       <= S_R;
          end
        end
        S_R: state <= S_RW;
        S_RW: begin
          if (!d_busy) begin
            rate_bias <= 21'(d_res);
            state     <= S_B;
          end
        end
        S_B: state <= S_BW;
        S_BW: if (!m_busy) state <= S_BD;
        S_BD: begin
          if (!d_busy) begin
            if (d_res > BIAS_MAX) axis_bias_y <= 25'sh0FFFFFF;
            else if (d_res < BIAS_MIN) axis_bias_y <= 25'sh1000000;
            else axis_bias_y <= 25'(d_res);
            calibrated <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_out.valid         <= 1'b1;
            result_out.forward_accel <= sat24(fwd_sum);
            result_out.yaw_rate      <= sat20(yaw_sum);
            result_out.out_tag       <= tag;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no result transaction may appear before calibration has finished
  a_no_result_uncal: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> calibrated)
    else $error("result produced before calibration");

  // the sequencer never runs two serial units at once
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(m_busy && d_busy) && !(m_busy && s_busy) && !(d_busy && s_busy))
    else $error("serial units overlap");

  // no sample taken while arithmetic is in flight
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (m_busy || d_busy || s_busy) |-> !sample_in.ready)
    else $error("sample accepted while busy");

  // once calibrated, the sample count is frozen until reset
  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    calibrated |=> $stable(sample_count) && calibrated)
    else $error("calibration state changed after calibration");
`endif

endmodule
